### src/utf8dec_pkg.sv
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared types and constants for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // lead byte classes
  typedef enum logic [1:0] {
    CLS_ASCII = 2'd0,
    CLS_LEAD  = 2'd1,
    CLS_BAD   = 2'd2
  } byte_cls_t;

  // one decoded step: repl_cnt replacement words, then the final word if present
  typedef struct packed {
    logic [1:0]      repl_cnt;
    logic            has_fin;
    logic [CP_W-1:0] fin_cp;
  } job_t;

  // head of the job queue as seen by the back end
  typedef struct packed {
    logic avail;
    job_t job;
  } q_head_t;

  // queue fill status
  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

### src/utf8dec_front.sv
// ----------------------------------------------------------------------------
// utf8dec_front
// Accepts text bytes, tracks the open sequence and emits one job per byte
// that gives any words.
// ----------------------------------------------------------------------------
module utf8dec_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [utf8dec_pkg::BYTE_W-1:0] text_byte,
  input  logic                          text_end,
  output logic                          job_push,
  output utf8dec_pkg::job_t             job
);
  import utf8dec_pkg::*;

  logic [CP_W-1:0] pv_r, pv_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [1:0]      exp_r, exp_nxt;

  byte_cls_t       cls;
  logic [1:0]      need;
  logic [CP_W-1:0] payload;
  logic            is_cont;
  logic [CP_W-1:0] pv_shift;
  logic [1:0]      held_inc;

  // classify the byte as a fresh lead
  always_comb begin
    need    = 2'd0;
    payload = '0;
    unique case (text_byte) inside
      [8'h00:8'h7F]: begin
        cls = CLS_ASCII;
      end
      [8'hC0:8'hDF]: begin
        cls     = CLS_LEAD;
        need    = 2'd1;
        payload = {16'd0, text_byte[4:0]};
      end
      [8'hE0:8'hEF]: begin
        cls     = CLS_LEAD;
        need    = 2'd2;
        payload = {17'd0, text_byte[3:0]};
      end
      [8'hF0:8'hF7]: begin
        cls     = CLS_LEAD;
        need    = 2'd3;
        payload = {18'd0, text_byte[2:0]};
      end
      default: begin
        cls = CLS_BAD;
      end
    endcase
  end

  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign pv_shift = {pv_r[CP_W-7:0], text_byte[5:0]};
  assign held_inc = held_r + 2'd1;

  // sequence tracking and job build
  always_comb begin
    pv_nxt       = pv_r;
    held_nxt     = held_r;
    exp_nxt      = exp_r;
    job.repl_cnt = 2'd0;
    job.has_fin  = 1'b0;
    job.fin_cp   = REPL_CP;
    if (exp_r != 2'd0 && is_cont) begin
      if (held_inc == exp_r) begin
        job.has_fin = 1'b1;
        job.fin_cp  = pv_shift;
        pv_nxt      = '0;
        held_nxt    = 2'd0;
        exp_nxt     = 2'd0;
      end else if (text_end) begin
        // lead and each held continuation give a replacement
        job.repl_cnt = held_inc;
        job.has_fin  = 1'b1;
        pv_nxt       = '0;
        held_nxt     = 2'd0;
        exp_nxt      = 2'd0;
      end else begin
        pv_nxt   = pv_shift;
        held_nxt = held_inc;
      end
    end else begin
      // broken sequence flushes first, then the byte decodes afresh
      if (exp_r != 2'd0) begin
        job.repl_cnt = held_inc;
      end
      pv_nxt   = '0;
      held_nxt = 2'd0;
      exp_nxt  = 2'd0;
      case (cls)
        CLS_ASCII: begin
          job.has_fin = 1'b1;
          job.fin_cp  = {13'd0, text_byte};
        end
        CLS_LEAD: begin
          if (text_end) begin
            job.has_fin = 1'b1;
          end else begin
            pv_nxt  = payload;
            exp_nxt = need;
          end
        end
        default: begin
          job.has_fin = 1'b1;
        end
      endcase
    end
  end

  assign job_push = acc && (job.has_fin || (job.repl_cnt != 2'd0));

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      held_r <= 2'd0;
      exp_r  <= 2'd0;
    end else if (acc) begin
      pv_r   <= pv_nxt;
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
    end
  end

endmodule

### src/utf8dec_queue.sv
// ----------------------------------------------------------------------------
// utf8dec_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module utf8dec_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  utf8dec_pkg::job_t     push_job,
  input  logic                  pop,
  output utf8dec_pkg::q_head_t  head,
  output utf8dec_pkg::q_stat_t  stat
);
  import utf8dec_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head.avail = (cnt_r != '0);
  assign head.job   = mem_r[rd_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.count = cnt_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/utf8dec_back.sv
// ----------------------------------------------------------------------------
// utf8dec_back
// Expands each job into output words, one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module utf8dec_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  utf8dec_pkg::q_head_t          head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8dec_pkg::CP_W-1:0]  out_code_point,
  output logic                          out_run_last
);
  import utf8dec_pkg::*;

  logic            busy_r;
  logic [1:0]      rem_r;
  logic            fin_r;
  logic [CP_W-1:0] cp_r;
  logic            take;
  logic            load;

  // current word
  assign out_valid      = busy_r;
  assign out_code_point = (rem_r != 2'd0) ? REPL_CP : cp_r;
  assign out_run_last   = (rem_r == 2'd0) || ((rem_r == 2'd1) && !fin_r);

  assign take = busy_r && !out_stall;
  assign load = head.avail && (!busy_r || (take && out_run_last));
  assign pop  = load;

  // word sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= 2'd0;
      fin_r  <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
      rem_r  <= head.job.repl_cnt;
      fin_r  <= head.job.has_fin;
    end else if (take) begin
      if (out_run_last) begin
        busy_r <= 1'b0;
      end else begin
        rem_r <= rem_r - 2'd1;
      end
    end
  end

  // final value
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r <= head.job.fin_cp;
    end
  end

endmodule

### src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: raw text bytes in, code points out.
// ----------------------------------------------------------------------------
//  channel | ports                                    | direction
//  --------+------------------------------------------+-----------
//  input   | in_valid, in_stall, in_text_byte,        | byte in
//          | in_text_end                              |
//  result  | out_valid, out_stall, out_code_point,    | word out
//          | out_run_last                             |
//
//  One byte is accepted per cycle while the four-entry job queue has room.
//  Each byte gives 0 to 4 words; the back end sends one word per cycle while
//  out_stall is low, so well-formed text runs at one byte per cycle. A byte's
//  job passes through the job queue and the back end's word registers.
//  rst_n is synchronous; it clears the open sequence, the queue and the
//  output stage. in_stall rises only when the job queue is full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8dec_pkg::BYTE_W-1:0] in_text_byte,
  input  logic                          in_text_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8dec_pkg::CP_W-1:0]  out_code_point,
  output logic                          out_run_last
);
  import utf8dec_pkg::*;

  logic    in_acc;
  logic    job_push;
  job_t    job;
  logic    pop;
  q_head_t head;
  q_stat_t stat;

  assign in_stall = stat.full;
  assign in_acc   = in_valid && !in_stall;

  // classify and track sequences
  utf8dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .text_byte (in_text_byte),
    .text_end  (in_text_end),
    .job_push  (job_push),
    .job       (job)
  );

  // job queue
  utf8dec_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // word expansion
  utf8dec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last)
  );

  // a job never lands in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && stat.full))
    else $error("job pushed into full queue");

  // occupancy stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  // a run continues after a word that is not its last
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_last) |=> out_valid)
    else $error("run cut short");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.avail)
    else $error("pop from empty queue");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_stream_decoder. A short table of hand-picked
// bytes comes first, then about 355 random bytes built mostly from well-formed
// sequences, with broken sequences and stray bytes mixed in. Each word out is
// compared with a behavioural decoder kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module testbench;
  import utf8dec_pkg::*;

  localparam int RANDOM_BYTES     = 355;
  localparam int LONG_HOLD_AFTER  = 120;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 1000;

  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            run_last;
  } cp_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              text_end;
  } text_item_t;

  // fixed rows carry their one expected word; the rest use the decoder below
  typedef struct packed {
    logic              fixed;
    logic [CP_W-1:0]   fixed_cp;
  } fixed_tag_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              text_end;
    logic              fixed;
    logic [CP_W-1:0]   fixed_cp;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [25] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000},  // lowest ascii
    '{8'h7F, 1'b1, 1'b1, 21'h00007F},  // highest ascii, end of text
    '{8'h80, 1'b0, 1'b1, REPL_CP},     // bare continuation
    '{8'hF8, 1'b0, 1'b1, REPL_CP},     // invalid lead range
    '{8'hFF, 1'b1, 1'b1, REPL_CP},
    '{8'hC3, 1'b0, 1'b0, 21'h0},       // two-byte sequence
    '{8'hA9, 1'b0, 1'b0, 21'h0},
    '{8'hE2, 1'b0, 1'b0, 21'h0},       // three-byte sequence
    '{8'h82, 1'b0, 1'b0, 21'h0},
    '{8'hAC, 1'b0, 1'b0, 21'h0},
    '{8'hF0, 1'b0, 1'b0, 21'h0},       // four-byte sequence
    '{8'h9F, 1'b0, 1'b0, 21'h0},
    '{8'h98, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'hF7, 1'b0, 1'b0, 21'h0},       // largest value a four-byte form holds
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hF0, 1'b0, 1'b0, 21'h0},       // sequence broken by ascii: four words
    '{8'h90, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'h41, 1'b0, 1'b0, 21'h0},
    '{8'hE0, 1'b0, 1'b0, 21'h0},       // end of text mid sequence
    '{8'h80, 1'b1, 1'b0, 21'h0},
    '{8'hC0, 1'b1, 1'b1, REPL_CP}      // end of text on a lead
  };

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_text_byte   = '0;
  logic              in_text_end    = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [CP_W-1:0]   out_code_point;
  logic              out_run_last;

  // decoder state
  logic [CP_W-1:0]   seq_value;
  logic [1:0]        seq_held;
  logic [1:0]        seq_need;

  cp_word_t          step_words[$];
  cp_word_t          pending_words[$];
  fixed_tag_t        fixed_q[$];
  text_item_t        text_q[$];

  int                fail_count    = 0;
  int                bytes_sent    = 0;
  int                words_checked = 0;
  int                flush_steps   = 0;
  int                idle_cycles   = 0;
  bit                rx_long_hold  = 1'b0;

  utf8_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_text_end    (in_text_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // behavioural decoder
  function automatic void emit(input logic [CP_W-1:0] cp);
    cp_word_t w;
    w.code_point = cp;
    w.run_last   = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void clear_seq();
    seq_value = '0;
    seq_held  = '0;
    seq_need  = '0;
  endfunction

  // byte seen with no sequence open
  function automatic void decode_fresh(input logic [BYTE_W-1:0] b, input logic e);
    logic [1:0]      need;
    logic [CP_W-1:0] payload;
    need    = '0;
    payload = '0;
    casez (b)
      8'b0???????: emit({13'b0, b});
      8'b110?????: begin
        need    = 2'd1;
        payload = {16'b0, b[4:0]};
      end
      8'b1110????: begin
        need    = 2'd2;
        payload = {17'b0, b[3:0]};
      end
      8'b11110???: begin
        need    = 2'd3;
        payload = {18'b0, b[2:0]};
      end
      default: emit(REPL_CP);
    endcase
    if (need != 0) begin
      if (e) begin
        emit(REPL_CP);
      end else begin
        seq_value = payload;
        seq_held  = '0;
        seq_need  = need;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic e);
    step_words.delete();
    if (seq_need != 0) begin
      if (b[7:6] == CONT_TAG) begin
        seq_value = {seq_value[CP_W-7:0], b[5:0]};
        seq_held  = seq_held + 2'd1;
        if (seq_held >= seq_need) begin
          emit(seq_value);
          clear_seq();
        end else if (e) begin
          emit(REPL_CP);
          repeat (seq_held) emit(REPL_CP);
          clear_seq();
        end
      end else begin
        // broken sequence: lead and held bytes each replaced, then start over
        emit(REPL_CP);
        repeat (seq_held) emit(REPL_CP);
        clear_seq();
        decode_fresh(b, e);
      end
    end else begin
      decode_fresh(b, e);
    end
    if (step_words.size() != 0)
      step_words[step_words.size()-1].run_last = 1'b1;
  endfunction

  // idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(3, 1);
    else if (r < 97)
      return $urandom_range(10, 4);
    else
      return $urandom_range(40, 16);
  endfunction

  function automatic void add_text_byte(input logic [BYTE_W-1:0] b);
    text_item_t it;
    it.text_byte = b;
    it.text_end  = ($urandom_range(19) == 0);
    text_q.insert(text_q.size(), it);
  endfunction

  function automatic logic [BYTE_W-1:0] lead_byte(input int len);
    logic [31:0] rnd;
    rnd = $urandom;
    case (len)
      1:       return {1'b0, rnd[6:0]};
      2:       return {3'b110, rnd[4:0]};
      3:       return {4'b1110, rnd[3:0]};
      default: return {5'b11110, rnd[2:0]};
    endcase
  endfunction

  // random text: mostly well-formed sequences, some broken, some stray bytes
  function automatic void build_random_text();
    int          kind;
    int          len;
    logic [31:0] rnd;
    logic [7:0]  b;
    while (text_q.size() < RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(4, 1);
        add_text_byte(lead_byte(len));
        repeat (len - 1) begin
          rnd = $urandom;
          add_text_byte({CONT_TAG, rnd[5:0]});
        end
      end else if (kind < 85) begin
        len = $urandom_range(4, 2);
        add_text_byte(lead_byte(len));
        repeat ($urandom_range(len - 2)) begin
          rnd = $urandom;
          add_text_byte({CONT_TAG, rnd[5:0]});
        end
        b = 8'($urandom);
        while (b[7:6] == CONT_TAG)
          b = 8'($urandom);
        add_text_byte(b);
      end else begin
        add_text_byte(8'($urandom));
      end
    end
  endfunction

  // offer one byte and hold it until taken
  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic e,
                            input logic fixed, input logic [CP_W-1:0] fixed_cp);
    fixed_tag_t tag;
    tag.fixed    = fixed;
    tag.fixed_cp = fixed_cp;
    fixed_q.insert(fixed_q.size(), tag);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_text_end  <= e;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = rx_long_hold ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // accepted bytes feed the decoder; accepted words are checked in order
  always @(posedge clk) begin : monitor
    fixed_tag_t tag;
    cp_word_t   want;
    cp_word_t   fix_word;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tag = fixed_q.pop_front();
        decode_byte(in_text_byte, in_text_end);
        if (step_words.size() > 1)
          flush_steps++;
        if (tag.fixed) begin
          fix_word.code_point = tag.fixed_cp;
          fix_word.run_last   = 1'b1;
          pending_words.insert(pending_words.size(), fix_word);
        end else begin
          foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
        end
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          $error("unexpected word: code_point %h run_last %b", out_code_point, out_run_last);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, out_code_point);
            fail_count++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_run_last);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin : receiver
    int  stall_left;
    int  tick;
    bit  long_done;
    stall_left = 0;
    tick       = 0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!long_done && words_checked >= LONG_HOLD_AFTER) begin
        long_done    = 1'b1;
        rx_long_hold = 1'b1;
        stall_left   = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        rx_long_hold = 1'b0;
        if ((tick % 200) >= 150 || $urandom_range(99) >= 25) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("utf8_stream_decoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, directed table, random text, drain
  initial begin : stimulus
    text_item_t item;
    int         pause_at;
    clear_seq();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      offer_byte(DIRECTED_ROWS[i].text_byte, DIRECTED_ROWS[i].text_end,
                 DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].fixed_cp);
      idle_sender();
    end

    build_random_text();
    pause_at = text_q.size() / 2;
    for (int n = 0; n < RANDOM_BYTES || text_q.size() != 0; n++) begin
      if (text_q.size() == 0)
        break;
      item = text_q.pop_front();
      offer_byte(item.text_byte, item.text_end, 1'b0, '0);
      idle_sender();
      // one pause until every pending word has drained
      if (n == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in, %0d code points out, %0d bytes giving several words",
             bytes_sent, words_checked, flush_steps);
    $display("receiver held off %0d cycles once; sender paused once for a full drain",
             LONG_HOLD_CYCLES);
    if (fail_count == 0)
      $display("utf8_stream_decoder test passed");
    else
      $display("utf8_stream_decoder test failed");
    $finish;
  end

endmodule
